>>> rtl/core/lws_pkg.sv
// ----------------------------------------------------------------------------
// Latency window statistics package
// Shared widths, reset values, register indexes and the status bundle that
// the serial accumulator hands to the controller.
// ----------------------------------------------------------------------------
package lws_pkg;

  localparam int SUM_BITS       = 64;
  localparam int STEP_BITS      = $clog2(SUM_BITS);
  localparam int LIMIT_BITS     = 32;
  localparam int COUNT_BITS     = 16;
  localparam int AVG_BITS       = 48;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [STEP_BITS-1:0]  STEP_LAST = STEP_BITS'(SUM_BITS - 1);

  localparam logic [LIMIT_BITS-1:0] LOW_LIMIT_RESET    = 32'd1500;
  localparam logic [LIMIT_BITS-1:0] MID_LIMIT_RESET    = 32'd2250;
  localparam logic [LIMIT_BITS-1:0] HIGH_LIMIT_RESET   = 32'd3750;
  localparam logic [COUNT_BITS-1:0] WINDOW_LIMIT_RESET = 16'd1000;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_LOW_LIMIT,
    REG_MID_LIMIT,
    REG_HIGH_LIMIT,
    REG_WINDOW_LIMIT
  } cfg_reg_t;

  typedef struct packed {
    logic done;
    logic below_low;
    logic below_mid;
    logic below_high;
  } acc_status_t;

endpackage

>>> rtl/core/lws_acc.sv
// ----------------------------------------------------------------------------
// Bit-serial latency accumulator
// Walks one bit per cycle, LSB first: subtracts the timestamps, adds the
// latency into the window sum and compares it against the three limits.
// ----------------------------------------------------------------------------
module lws_acc
  import lws_pkg::*;
#(
  parameter int TIME_BITS = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  clear,
  input  logic [TIME_BITS-1:0]  request_time,
  input  logic [TIME_BITS-1:0]  reply_time,
  input  logic [LIMIT_BITS-1:0] low_limit,
  input  logic [LIMIT_BITS-1:0] mid_limit,
  input  logic [LIMIT_BITS-1:0] high_limit,
  output logic [SUM_BITS-1:0]   sum,
  output acc_status_t           status
);

  logic                  busy;
  logic                  done;
  logic [STEP_BITS-1:0]  step;
  logic [TIME_BITS-1:0]  req_sh;
  logic [TIME_BITS-1:0]  rep_sh;
  logic [LIMIT_BITS-1:0] low_sh;
  logic [LIMIT_BITS-1:0] mid_sh;
  logic [LIMIT_BITS-1:0] high_sh;
  logic                  borrow;
  logic                  carry;
  logic                  lt_low;
  logic                  lt_mid;
  logic                  lt_high;

  logic in_range;
  logic lat_bit;
  logic borrow_next;
  logic sum_bit;
  logic carry_next;

  // LSB-first less-than: a higher equal bit keeps the verdict of the lower bits
  function automatic logic lt_step(input logic a, input logic b, input logic lt);
    return (~a & b) | (~(a ^ b) & lt);
  endfunction

  always_comb begin
    in_range    = {1'b0, step} < (STEP_BITS + 1)'(TIME_BITS);
    lat_bit     = in_range & (rep_sh[0] ^ req_sh[0] ^ borrow);
    borrow_next = (~rep_sh[0] & req_sh[0]) | (~(rep_sh[0] ^ req_sh[0]) & borrow);
    sum_bit     = sum[0] ^ lat_bit ^ carry;
    carry_next  = (sum[0] & lat_bit) | (carry & (sum[0] ^ lat_bit));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      sum  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        step    <= '0;
        req_sh  <= request_time;
        rep_sh  <= reply_time;
        low_sh  <= low_limit;
        mid_sh  <= mid_limit;
        high_sh <= high_limit;
        borrow  <= 1'b0;
        carry   <= 1'b0;
        lt_low  <= 1'b0;
        lt_mid  <= 1'b0;
        lt_high <= 1'b0;
      end else if (busy) begin
        req_sh  <= req_sh >> 1;
        rep_sh  <= rep_sh >> 1;
        low_sh  <= low_sh >> 1;
        mid_sh  <= mid_sh >> 1;
        high_sh <= high_sh >> 1;
        borrow  <= borrow_next;
        carry   <= carry_next;
        lt_low  <= lt_step(lat_bit, low_sh[0], lt_low);
        lt_mid  <= lt_step(lat_bit, mid_sh[0], lt_mid);
        lt_high <= lt_step(lat_bit, high_sh[0], lt_high);
        // rotate the sum through the adder, one bit per cycle
        sum     <= {sum_bit, sum[SUM_BITS-1:1]};
        step    <= step + 1'b1;
        if (step == STEP_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
      if (clear) begin
        sum <= '0;
      end
    end
  end

  assign status = '{done: done, below_low: lt_low, below_mid: lt_mid,
                    below_high: lt_high};

endmodule

>>> rtl/core/lws_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring radix-2 division of the window sum by the sample count,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lws_div
  import lws_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [SUM_BITS-1:0]   dividend,
  input  logic [COUNT_BITS-1:0] divisor,
  output logic [SUM_BITS-1:0]   quotient,
  output logic                  done
);

  logic                  busy;
  logic [STEP_BITS-1:0]  step;
  logic [COUNT_BITS-1:0] dsor;
  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS:0]   trial;
  logic                  fits;

  always_comb begin
    trial = {rem, quotient[SUM_BITS-1]};
    fits  = trial >= {1'b0, dsor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step     <= '0;
        dsor     <= divisor;
        rem      <= '0;
        quotient <= dividend;
      end else if (busy) begin
        // the remainder stays below the divisor, so it fits in COUNT_BITS
        rem      <= fits ? COUNT_BITS'(trial - {1'b0, dsor}) : COUNT_BITS'(trial);
        quotient <= {quotient[SUM_BITS-2:0], fits};
        step     <= step + 1'b1;
        if (step == STEP_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/core/latency_window_statistics.sv
// Datapath: an accepted request passes through the bit-serial accumulator
// (one bit of the 64-bit sum per cycle); a request that closes a window then
// passes through the serial divider before the report is registered.
// Input stall: raised while the accumulator, the divider or the report hold is busy.
// Reset: synchronous, active high; clears the window, restores limit defaults.
// ----------------------------------------------------------------------------
// Latency window statistics
// Accumulates request/reply latencies per window, bins them against three
// limits and reports the average and bin counts when the window fills.
// ----------------------------------------------------------------------------
module latency_window_statistics
  import lws_pkg::*;
#(
  parameter int TIME_BITS = 48
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      config_write,
  input  logic [CFG_INDEX_BITS-1:0] config_index,
  input  logic [CFG_DATA_BITS-1:0]  config_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [TIME_BITS-1:0]      request_time,
  input  logic [TIME_BITS-1:0]      reply_time,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [AVG_BITS-1:0]       average_latency,
  output logic [COUNT_BITS-1:0]     low_count,
  output logic [COUNT_BITS-1:0]     mid_count,
  output logic [COUNT_BITS-1:0]     high_count,
  output logic [COUNT_BITS-1:0]     over_count,
  output logic [COUNT_BITS-1:0]     window_samples
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACC,
    S_DIV,
    S_HOLD
  } state_t;

  state_t                state;
  logic [LIMIT_BITS-1:0] low_limit;
  logic [LIMIT_BITS-1:0] mid_limit;
  logic [LIMIT_BITS-1:0] high_limit;
  logic [COUNT_BITS-1:0] window_limit;
  logic [COUNT_BITS-1:0] sample_count;
  logic [COUNT_BITS-1:0] low_bin;
  logic [COUNT_BITS-1:0] mid_bin;
  logic [COUNT_BITS-1:0] high_bin;

  logic                  accept;
  logic                  out_free;
  logic                  acc_clear;
  logic                  div_start;
  logic                  div_done;
  logic                  report;
  logic [COUNT_BITS-1:0] count_next;
  logic [SUM_BITS-1:0]   sum;
  logic [SUM_BITS-1:0]   quotient;
  acc_status_t           acc_status;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid & ~in_stall;
  assign out_free  = ~out_valid | ~out_stall;
  assign acc_clear = (state == S_HOLD) & out_free;

  always_comb begin
    count_next = sample_count + 1'b1;
    // a full counter forces the report so nothing can wrap
    report     = (count_next > window_limit) || (count_next == '1);
    div_start  = (state == S_ACC) & acc_status.done & report;
  end

  lws_acc #(
    .TIME_BITS (TIME_BITS)
  ) u_acc (
    .clk          (clk),
    .rst          (rst),
    .start        (accept),
    .clear        (acc_clear),
    .request_time (request_time),
    .reply_time   (reply_time),
    .low_limit    (low_limit),
    .mid_limit    (mid_limit),
    .high_limit   (high_limit),
    .sum          (sum),
    .status       (acc_status)
  );

  lws_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (count_next),
    .quotient (quotient),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      low_limit    <= LOW_LIMIT_RESET;
      mid_limit    <= MID_LIMIT_RESET;
      high_limit   <= HIGH_LIMIT_RESET;
      window_limit <= WINDOW_LIMIT_RESET;
      sample_count <= '0;
      low_bin      <= '0;
      mid_bin      <= '0;
      high_bin     <= '0;
    end else begin
      if (config_write) begin
        case (cfg_reg_t'(config_index))
          REG_LOW_LIMIT:    low_limit    <= config_data;
          REG_MID_LIMIT:    mid_limit    <= config_data;
          REG_HIGH_LIMIT:   high_limit   <= config_data;
          REG_WINDOW_LIMIT: window_limit <= config_data[COUNT_BITS-1:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (acc_status.done) begin
            sample_count <= count_next;
            // first limit that passes takes the sample
            if (acc_status.below_low) begin
              low_bin <= low_bin + 1'b1;
            end else if (acc_status.below_mid) begin
              mid_bin <= mid_bin + 1'b1;
            end else if (acc_status.below_high) begin
              high_bin <= high_bin + 1'b1;
            end
            state <= report ? S_DIV : S_IDLE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          // hold the report until the output register frees up
          if (out_free) begin
            out_valid       <= 1'b1;
            average_latency <= quotient[AVG_BITS-1:0];
            low_count       <= low_bin;
            mid_count       <= mid_bin;
            high_count      <= high_bin;
            over_count      <= sample_count - low_bin - mid_bin - high_bin;
            window_samples  <= sample_count;
            sample_count    <= '0;
            low_bin         <= '0;
            mid_bin         <= '0;
            high_bin        <= '0;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/lws_checker.sv
// ----------------------------------------------------------------------------
// Latency window statistics checker
// Port-level properties of the report channel and the input handshake.
// ----------------------------------------------------------------------------
module lws_checker
  import lws_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [COUNT_BITS-1:0] low_count,
  input logic [COUNT_BITS-1:0] mid_count,
  input logic [COUNT_BITS-1:0] high_count,
  input logic [COUNT_BITS-1:0] over_count,
  input logic [COUNT_BITS-1:0] window_samples
);

  // a report always covers at least one sample
  a_nonempty_window: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> window_samples != '0)
    else $error("report with an empty window");

  // the bins and the over-limit count partition the window
  a_bins_partition: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> COUNT_BITS'(low_count + mid_count + high_count + over_count)
                  == window_samples)
    else $error("bin counts do not add up to the window size");

  // an accepted request keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accepting a request");

  a_report_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(window_samples))
    else $error("stalled report dropped or changed");

endmodule

bind latency_window_statistics lws_checker u_lws_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .low_count      (low_count),
  .mid_count      (mid_count),
  .high_count     (high_count),
  .over_count     (over_count),
  .window_samples (window_samples)
);
